@@ rtl/coin_change_way_counter_assert.svh @@
// Assertion macros for the coin change way counter.
`ifndef COIN_CHANGE_WAY_COUNTER_ASSERT_SVH
`define COIN_CHANGE_WAY_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define CCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ccw_pkg.sv @@
`default_nettype none

package ccw_pkg;

   localparam int WAYS_W   = 63;
   localparam int COIN_W   = 10;
   localparam int TARGET_W = 10;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_READ,
      ST_RESULT
   } ccw_state_type;

   typedef struct packed {
      logic              valid;
      logic [WAYS_W-1:0] ways;
      logic              saturated;
   } ccw_result_type;

   typedef struct packed {
      logic clearing;
      logic sweeping;
   } ccw_status_type;

endpackage

`default_nettype wire

@@ rtl/ccw_table.sv @@
`default_nettype none

module ccw_table
   import ccw_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr_a,
   input  wire logic [AW-1:0]     rd_addr_b,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WAYS_W-1:0] wr_data,
   output logic      [WAYS_W-1:0] rd_data_a,
   output logic      [WAYS_W-1:0] rd_data_b
);

   logic [WAYS_W-1:0] mem [DEPTH];
   logic [WAYS_W-1:0] q_a_ff;
   logic [WAYS_W-1:0] q_b_ff;
   logic [WAYS_W-1:0] fwd_data_ff;
   logic              fwd_a_ff;
   logic              fwd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_a_ff      <= mem[rd_addr_a];
         q_b_ff      <= mem[rd_addr_b];
         fwd_data_ff <= wr_data;
      end
   end

   // a read that meets a write to the same entry takes the new data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_a_ff <= 1'b0;
         fwd_b_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_a_ff <= wr_en && (wr_addr == rd_addr_a);
         fwd_b_ff <= wr_en && (wr_addr == rd_addr_b);
      end
   end

   assign rd_data_a = fwd_a_ff ? fwd_data_ff : q_a_ff;
   assign rd_data_b = fwd_b_ff ? fwd_data_ff : q_b_ff;

endmodule

`default_nettype wire

@@ rtl/ccw_ctrl.sv @@
`default_nettype none

module ccw_ctrl
   import ccw_pkg::*;
#(
   parameter int MAX_AMOUNT = 1023,
   parameter int AW         = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [COIN_W-1:0]   req_coin_value,
   input  wire logic                req_last_coin,
   input  wire logic [TARGET_W-1:0] target_amount,
   input  wire logic                res_ready,
   output ccw_result_type           res,
   output ccw_status_type           status,
   output logic                     rd_en,
   output logic      [AW-1:0]       rd_addr_a,
   output logic      [AW-1:0]       rd_addr_b,
   output logic                     wr_en,
   output logic      [AW-1:0]       wr_addr,
   output logic      [WAYS_W-1:0]   wr_data,
   input  wire logic [WAYS_W-1:0]   rd_data_a,
   input  wire logic [WAYS_W-1:0]   rd_data_b
);

   localparam int TW = (AW > TARGET_W) ? AW : TARGET_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_AMOUNT);

   ccw_state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] j_ff, j_in;
   logic [AW-1:0] coin_ff, coin_in;
   logic [AW-1:0] t_ff, t_in;
   logic          last_ff, last_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] waddr_ff, waddr_in;
   logic          overflow_ff, overflow_in;

   logic [TW-1:0]     coin_ext;
   logic [TW-1:0]     tgt_ext;
   logic [TW-1:0]     tgt_eff;
   logic              coin_used;
   logic [WAYS_W:0]   sum;
   logic              sum_ovf;
   logic [WAYS_W-1:0] sum_sat;

   assign coin_ext  = TW'(req_coin_value);
   assign tgt_ext   = TW'(target_amount);
   assign tgt_eff   = (tgt_ext > TW'(MAX_AMOUNT)) ? TW'(MAX_AMOUNT) : tgt_ext;
   assign coin_used = (coin_ext != '0) && (coin_ext <= tgt_eff);

   // entry j plus entry j-coin, clamped to the largest 63-bit value
   assign sum     = {1'b0, rd_data_a} + {1'b0, rd_data_b};
   assign sum_ovf = sum[WAYS_W];
   assign sum_sat = sum_ovf ? {WAYS_W{1'b1}} : sum[WAYS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         pend_ff     <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         pend_ff     <= pend_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff     <= j_in;
      coin_ff  <= coin_in;
      t_ff     <= t_in;
      last_ff  <= last_in;
      waddr_ff <= waddr_in;
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      j_in        = j_ff;
      coin_in     = coin_ff;
      t_in        = t_ff;
      last_in     = last_ff;
      pend_in     = 1'b0;
      waddr_in    = j_ff;
      overflow_in = overflow_ff;

      req_stall   = 1'b1;
      rd_en       = 1'b0;
      rd_addr_a   = j_ff;
      rd_addr_b   = j_ff - coin_ff;
      wr_en       = pend_ff;
      wr_addr     = waddr_ff;
      wr_data     = sum_sat;

      res.valid     = 1'b0;
      res.ways      = rd_data_a;
      res.saturated = overflow_ff;

      status.clearing = 1'b0;
      status.sweeping = 1'b0;

      // write-back of the step read in the previous cycle
      if (pend_ff && sum_ovf) begin
         overflow_in = 1'b1;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            status.clearing = 1'b1;
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = (clr_ff == '0) ? WAYS_W'(1) : '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               j_in    = coin_ext[AW-1:0];
               coin_in = coin_ext[AW-1:0];
               t_in    = tgt_eff[AW-1:0];
               last_in = req_last_coin;
               if (coin_used) begin
                  state_in = ST_SWEEP;
               end else if (req_last_coin) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SWEEP: begin
            status.sweeping = 1'b1;
            rd_en   = 1'b1;
            pend_in = 1'b1;
            j_in    = j_ff + AW'(1);
            if (j_ff == t_ff) begin
               state_in = last_ff ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            rd_en     = 1'b1;
            rd_addr_a = t_ff;
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            res.valid = 1'b1;
            if (res_ready) begin
               overflow_in = 1'b0;
               clr_in      = '0;
               state_in    = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/coin_change_way_counter.sv @@
// A nonzero coin c not above the target is accepted, then swept over entries c through the target;
// a zero coin or one above the target is accepted with no sweep.
// After a last coin (and its sweep, if any), a read state fetches the target entry, then the result is offered.
// The sweep handles one table entry per cycle, set by the read-add-write loop on the table memory.
// Reset: control clears, then a clearing pass rewrites all MAX_AMOUNT+1 table entries;
// the same pass runs after every result, and req_stall stays high during it.
`default_nettype none

module coin_change_way_counter
   import ccw_pkg::*;
#(
   parameter int MAX_AMOUNT = 1023
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [COIN_W-1:0]   req_coin_value,
   input  wire logic                req_last_coin,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [WAYS_W-1:0]   rsp_ways,
   output logic                     rsp_saturated,
   input  wire logic                csr_wr_en,
   input  wire logic [TARGET_W-1:0] csr_target_amount
);

   localparam int DEPTH = MAX_AMOUNT + 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [TARGET_W-1:0] target_ff;
   logic                rsp_valid_ff;
   logic [WAYS_W-1:0]   rsp_ways_ff;
   logic                rsp_saturated_ff;

   ccw_result_type res;
   ccw_status_type status;
   logic           res_ready;

   logic              rd_en;
   logic [AW-1:0]     rd_addr_a;
   logic [AW-1:0]     rd_addr_b;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WAYS_W-1:0] wr_data;
   logic [WAYS_W-1:0] rd_data_a;
   logic [WAYS_W-1:0] rd_data_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_wr_en) begin
         target_ff <= csr_target_amount;
      end
   end

   ccw_ctrl #(
      .MAX_AMOUNT (MAX_AMOUNT),
      .AW         (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_coin_value (req_coin_value),
      .req_last_coin  (req_last_coin),
      .target_amount  (target_ff),
      .res_ready      (res_ready),
      .res            (res),
      .status         (status),
      .rd_en          (rd_en),
      .rd_addr_a      (rd_addr_a),
      .rd_addr_b      (rd_addr_b),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_data_a      (rd_data_a),
      .rd_data_b      (rd_data_b)
   );

   ccw_table #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // output register: a new result loads once the previous one has transferred
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid && res_ready) begin
         rsp_ways_ff      <= res.ways;
         rsp_saturated_ff <= res.saturated;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ways      = rsp_ways_ff;
   assign rsp_saturated = rsp_saturated_ff;

`include "coin_change_way_counter_assert.svh"

   `CCW_ASSERT_NOW(a_clear_blocks_input, clock, reset, status.clearing, req_stall,
      "input taken during table clear")
   `CCW_ASSERT_NOW(a_sweep_blocks_input, clock, reset, status.sweeping, req_stall,
      "input taken during sweep")
   `CCW_ASSERT_NEXT(a_result_loaded, clock, reset, res.valid && res_ready, rsp_valid,
      "result not loaded into output register")
   `CCW_ASSERT_NEXT(a_clear_after_result, clock, reset, res.valid && res_ready,
      status.clearing, "table clear did not follow result")

endmodule

`default_nettype wire

@@ tb/sv/tb_coin_change_way_counter.sv @@
module tb_coin_change_way_counter;
   import ccw_pkg::*;

   localparam int TOP_AMOUNT  = 1023;
   localparam int SETTLE      = 2200;    // longest sweep plus a clearing pass, with margin
   localparam int DRAIN_LIMIT = 400000;
   localparam int HOLD_CYCLES = 3000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 44;

   typedef struct packed {
      logic [COIN_W-1:0] coin;
      logic              last;
   } coin_item_type;

   typedef struct packed {
      logic [WAYS_W-1:0] ways;
      logic              sat;
   } way_count_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [COIN_W-1:0]   req_coin_value = '0;
   logic                req_last_coin = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [WAYS_W-1:0]   rsp_ways;
   logic                rsp_saturated;
   logic                csr_wr_en = 1'b0;
   logic [TARGET_W-1:0] csr_target_amount = '0;

   // predictor state
   logic [WAYS_W-1:0]   partial_ways [0:TOP_AMOUNT];
   logic                ways_clamped;
   logic [TARGET_W-1:0] sweep_limit;

   coin_item_type coin_feed [$];
   coin_item_type feed_head;
   way_count_type count_due [$];
   way_count_type count_now;

   bit req_took = 1'b0;
   bit calm = 1'b0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int bad_count = 0;

   coin_change_way_counter uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_coin_value    (req_coin_value),
      .req_last_coin     (req_last_coin),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ways          (rsp_ways),
      .rsp_saturated     (rsp_saturated),
      .csr_wr_en         (csr_wr_en),
      .csr_target_amount (csr_target_amount)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_ways();
      for (int i = 0; i <= TOP_AMOUNT; i++)
         partial_ways[i] = '0;
      partial_ways[0] = WAYS_W'(1);
      ways_clamped = 1'b0;
   endfunction

   // one coin kind: unbounded use, so entries are swept in rising order
   function automatic void add_coin(input logic [COIN_W-1:0] coin);
      logic [WAYS_W:0] sum;
      if (coin != '0 && coin <= sweep_limit) begin
         for (int j = int'(coin); j <= int'(sweep_limit); j++) begin
            sum = {1'b0, partial_ways[j]} + {1'b0, partial_ways[j - int'(coin)]};
            if (sum[WAYS_W]) begin
               partial_ways[j] = '1;
               ways_clamped = 1'b1;
            end else begin
               partial_ways[j] = sum[WAYS_W-1:0];
            end
         end
      end
   endfunction

   initial begin
      clear_ways();
      sweep_limit = '0;
   end

   // input driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (coin_feed.size() > 0 && (calm || $urandom_range(0, 99) >= 7)) begin
            feed_head = coin_feed.pop_front();
            req_valid <= 1'b1;
            req_coin_value <= feed_head.coin;
            req_last_coin <= feed_head.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 7);
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      req_took = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (csr_wr_en)
            sweep_limit = csr_target_amount;
         if (req_took) begin
            add_coin(req_coin_value);
            if (req_last_coin) begin
               count_now.ways = partial_ways[sweep_limit];
               count_now.sat = ways_clamped;
               count_due.push_back(count_now);
               clear_ways();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (count_due.size() == 0) begin
               $error("result transfer with no count pending");
               bad_count++;
            end else begin
               count_now = count_due.pop_front();
               if (rsp_ways !== count_now.ways) begin
                  $error("ways: expected %0d, actual %0d", count_now.ways, rsp_ways);
                  bad_count++;
               end
               if (rsp_saturated !== count_now.sat) begin
                  $error("saturated: expected %0d, actual %0d", count_now.sat, rsp_saturated);
                  bad_count++;
               end
            end
         end
      end
   end

   task automatic drain(input int settle);
      int guard;
      guard = 0;
      while ((coin_feed.size() > 0 || req_valid || count_due.size() > 0)
             && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_target(input logic [TARGET_W-1:0] amt);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_target_amount <= amt;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_coin(input logic [COIN_W-1:0] coin, input logic last);
      coin_item_type it;
      it.coin = coin;
      it.last = last;
      coin_feed.push_back(it);
   endtask

   // problems with random coins; the final one may stay open into the next phase
   task automatic queue_problems(input logic [TARGET_W-1:0] amt, input int count);
      int left;
      int len;
      int pick;
      bit open_end;
      logic [COIN_W-1:0] coin;
      left = count;
      open_end = ($urandom_range(0, 2) == 0);
      while (left > 0) begin
         len = $urandom_range(1, 6);
         if (len > left)
            len = left;
         for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               coin = '0;
            else if (pick == 1)
               coin = COIN_W'($urandom_range(0, TOP_AMOUNT));
            else
               coin = COIN_W'($urandom_range(1, (amt == '0) ? 1 : int'(amt)));
            push_coin(coin, (k == len - 1) && !(open_end && left == len));
         end
         left -= len;
      end
   endtask

   initial begin
      logic [TARGET_W-1:0] amt;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      drain(SETTLE);

      // target still at its reset value of zero: empty problem, coin above target
      push_coin('0, 1'b1);
      push_coin(10'd1023, 1'b1);
      drain(SETTLE);

      // widest target with many small coins drives the counts into saturation
      write_target(10'd1023);
      for (int c = 1; c <= 17; c++)
         push_coin(COIN_W'(c), 1'b0);
      push_coin(10'd1023, 1'b1);
      drain(SETTLE);

      // target raised in the middle of a problem
      write_target(10'd1);
      push_coin(10'd1, 1'b0);
      drain(SETTLE);
      write_target(10'd10);
      push_coin(10'd2, 1'b0);
      push_coin(10'd10, 1'b1);
      drain(SETTLE);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: amt = '0;
            1: amt = 10'd1023;
            default: amt = ($urandom_range(0, 7) == 0)
                           ? TARGET_W'($urandom_range(0, TOP_AMOUNT))
                           : TARGET_W'($urandom_range(1, 60));
         endcase
         write_target(amt);
         calm = (ph == 4);
         if (ph == 2)
            hold_armed = 1'b1;
         queue_problems(amt, PHASE_ITEMS);
         drain(SETTLE);
      end

      if (count_due.size() > 0) begin
         $error("%0d counts never delivered", count_due.size());
         bad_count++;
      end
      if (bad_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #64000000;
      $display("Verification failed");
      $finish;
   end

endmodule
